[rtl/c8cpu_pkg.sv]
// Shared constants, font table and opcode codes for the CHIP-8 core.
`timescale 1ns / 1ps
`default_nettype none
package c8cpu_pkg;

  localparam int MemBytes   = 4096;
  localparam int StackDepth = 16;
  localparam int ScreenCols = 64;
  localparam int ScreenRows = 32;
  localparam int FontBytes  = 80;

  localparam logic [11:0] PROGRAM_START = 12'd512;
  localparam logic [4:0]  NO_KEY        = 5'd16;
  localparam logic [3:0]  FLAG_REG      = 4'hf;

  // command codes of an input item
  localparam logic [1:0] OP_RESTART = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_STEP    = 2'd2;
  localparam logic [1:0] OP_READ    = 2'd3;

  localparam logic [7:0] HEX_FONT [FontBytes] = '{
    8'hf0, 8'h90, 8'h90, 8'h90, 8'hf0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
    8'hf0, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h10, 8'hf0, 8'h10, 8'hf0,
    8'h90, 8'h90, 8'hf0, 8'h10, 8'h10, 8'hf0, 8'h80, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h80, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h10, 8'h20, 8'h40, 8'h40,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'hf0, 8'hf0, 8'h90, 8'hf0, 8'h10, 8'hf0,
    8'hf0, 8'h90, 8'hf0, 8'h90, 8'h90, 8'he0, 8'h90, 8'he0, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'h80, 8'h80, 8'hf0, 8'he0, 8'h90, 8'h90, 8'h90, 8'he0,
    8'hf0, 8'h80, 8'hf0, 8'h80, 8'hf0, 8'hf0, 8'h80, 8'hf0, 8'h80, 8'h80
  };

endpackage
`default_nettype wire

[rtl/chip8_cpu_core_unit.sv]
// CHIP-8 CPU core: command sequencer around program, register, stack and frame RAMs.
//
// Usage: drive opcode_i and its operands with start high; the item is taken at
// a clock edge where busy is low. Every item gives one result, shown on the
// result ports for exactly one cycle with done_o high; the receiver cannot
// stall, so it must sample done_o every cycle.
// From accept to done_o: load byte writes the byte on accept; read row reads
//   the frame RAM and registers the row; step fetches two bytes, reads Vx
//   and Vy, executes and finishes, with an extra state for a flag write or
//   RET; clear screen zeroes every row, draw reads and XORs each sprite row,
//   Fx33 writes three digits, Fx55/Fx65 move one register per pass. One item
//   is handled at a time, walking per-instruction states over the simple
//   dual-port RAMs. Restart: a sweep writes all 4096 program bytes (font at
//   the bottom) and clears registers, stack and screen, one address a cycle.
// After reset the same sweep runs with busy high and no result.
// busy drops in the same cycle a result is shown, so a new item may be taken
// in the very cycle its predecessor's result is shown.
`timescale 1ns / 1ps
`default_nettype none
module chip8_cpu_core_unit
  import c8cpu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [11:0] address_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic [15:0] keys_i,
  input  wire logic [7:0]  random_byte_i,
  input  wire logic [4:0]  row_index_i,
  output logic             busy,
  output logic             done_o,
  output logic [11:0]      program_counter_o,
  output logic [15:0]      fetched_word_o,
  output logic             halted_o,
  output logic             display_changed_o,
  output logic             sound_on_o,
  output logic             unknown_instruction_o,
  output logic [63:0]      row_pixels_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_CLR  = 5'd1;
  localparam logic [4:0] S_ROW  = 5'd2;
  localparam logic [4:0] S_F0   = 5'd3;
  localparam logic [4:0] S_F1   = 5'd4;
  localparam logic [4:0] S_F2   = 5'd5;
  localparam logic [4:0] S_RX   = 5'd6;
  localparam logic [4:0] S_RY   = 5'd7;
  localparam logic [4:0] S_EX   = 5'd8;
  localparam logic [4:0] S_RET  = 5'd9;
  localparam logic [4:0] S_FLG  = 5'd10;
  localparam logic [4:0] S_CLS  = 5'd11;
  localparam logic [4:0] S_DR0  = 5'd12;
  localparam logic [4:0] S_DR1  = 5'd13;
  localparam logic [4:0] S_DR2  = 5'd14;
  localparam logic [4:0] S_BCD  = 5'd15;
  localparam logic [4:0] S_ST0  = 5'd16;
  localparam logic [4:0] S_ST1  = 5'd17;
  localparam logic [4:0] S_LD0  = 5'd18;
  localparam logic [4:0] S_LD1  = 5'd19;
  localparam logic [4:0] S_FIN  = 5'd20;

  // control state
  logic [4:0]  state_q, state_d;
  logic [11:0] clr_q, clr_d;
  logic        emit_q, emit_d;
  logic [11:0] pc_q, pc_d;
  logic [15:0] idx_q, idx_d;
  logic [3:0]  sp_q, sp_d;
  logic [7:0]  dly_q, dly_d;
  logic [7:0]  snd_q, snd_d;
  logic        wait_q, wait_d;
  logic [4:0]  held_q, held_d;
  logic        done_q, done_d;

  // per-step working registers
  logic [15:0] keys_q, keys_d;
  logic [7:0]  rnd_q, rnd_d;
  logic [7:0]  hi_q, hi_d;
  logic [15:0] word_q, word_d;
  logic [7:0]  vx_q, vx_d;
  logic [7:0]  vy_q, vy_d;
  logic        adv_q, adv_d;
  logic        unk_q, unk_d;
  logic        chg_q, chg_d;
  logic        flag_q, flag_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [7:0]  sprite_q, sprite_d;
  logic [11:0] bcd_q, bcd_d;

  // result registers
  logic [11:0] res_pc_q, res_pc_d;
  logic [15:0] res_word_q, res_word_d;
  logic        res_halt_q, res_halt_d;
  logic        res_chg_q, res_chg_d;
  logic        res_snd_q, res_snd_d;
  logic        res_unk_q, res_unk_d;
  logic [63:0] res_row_q, res_row_d;

  // RAM ports
  logic        m_we;
  logic [11:0] m_waddr, m_raddr;
  logic [7:0]  m_wdata, m_rdata;
  logic        v_we;
  logic [3:0]  v_waddr, v_raddr;
  logic [7:0]  v_wdata, v_rdata;
  logic        s_we;
  logic [3:0]  s_waddr;
  logic [11:0] s_wdata, s_rdata;
  logic        f_we;
  logic [4:0]  f_waddr, f_raddr;
  logic [63:0] f_wdata, f_rdata;

  // decode and datapath helpers
  logic [3:0]   ins_x, ins_y, ins_n;
  logic [7:0]   ins_kk;
  logic [11:0]  ins_nnn;
  logic         is_key_wait;
  logic [11:0]  idx_off;
  logic [4:0]   draw_row;
  logic [127:0] spr_wide;
  logic [63:0]  draw_mask;
  logic [8:0]   sum9;
  logic [7:0]   alu_res;
  logic         alu_flag;
  logic         alu_ok;
  logic [3:0]   top_key;
  logic         any_key;
  logic [1:0]   bcd_h;
  logic [6:0]   bcd_r;
  logic [14:0]  tens_prod;
  logic [3:0]   bcd_t;
  logic [7:0]   bcd_o;
  logic [11:0]  pc_fin;
  logic [7:0]   snd_fin;

  c8cpu_ram #(.Width(8), .Depth(MemBytes)) u_mem (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .raddr_i(m_raddr), .rdata_o(m_rdata)
  );
  c8cpu_ram #(.Width(8), .Depth(16)) u_vreg (
    .clk_i, .we_i(v_we), .waddr_i(v_waddr), .wdata_i(v_wdata),
    .raddr_i(v_raddr), .rdata_o(v_rdata)
  );
  c8cpu_ram #(.Width(12), .Depth(StackDepth)) u_stack (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(sp_q), .rdata_o(s_rdata)
  );
  c8cpu_ram #(.Width(64), .Depth(ScreenRows)) u_frame (
    .clk_i, .we_i(f_we), .waddr_i(f_waddr), .wdata_i(f_wdata),
    .raddr_i(f_raddr), .rdata_o(f_rdata)
  );

  assign ins_x       = word_q[11:8];
  assign ins_y       = word_q[7:4];
  assign ins_n       = word_q[3:0];
  assign ins_kk      = word_q[7:0];
  assign ins_nnn     = word_q[11:0];
  assign is_key_wait = (word_q[15:12] == 4'hf) && (ins_kk == 8'h0a);
  assign idx_off     = idx_q[11:0] + {8'd0, cnt_q[3:0]};
  assign draw_row    = vy_q[4:0] + {1'b0, cnt_q[3:0]};
  // sprite byte placed at column 0, rotated right so columns wrap
  assign spr_wide    = {sprite_q, 56'd0, sprite_q, 56'd0} >> vx_q[5:0];
  assign draw_mask   = spr_wide[63:0];
  assign sum9        = {1'b0, vx_q} + {1'b0, v_rdata};

  // ALU for 8xyn; v_rdata holds Vy during execute
  always_comb begin
    alu_res  = v_rdata;
    alu_flag = 1'b0;
    alu_ok   = 1'b1;
    case (ins_n)
      4'h0: alu_res = v_rdata;
      4'h1: alu_res = vx_q | v_rdata;
      4'h2: alu_res = vx_q & v_rdata;
      4'h3: alu_res = vx_q ^ v_rdata;
      4'h4: begin
        alu_res  = sum9[7:0];
        alu_flag = sum9[8];
      end
      4'h5: begin
        alu_res  = vx_q - v_rdata;
        alu_flag = vx_q >= v_rdata;
      end
      4'h6: begin
        alu_res  = {1'b0, vx_q[7:1]};
        alu_flag = vx_q[0];
      end
      4'h7: begin
        alu_res  = v_rdata - vx_q;
        alu_flag = v_rdata >= vx_q;
      end
      4'he: begin
        alu_res  = {vx_q[6:0], 1'b0};
        alu_flag = vx_q[7];
      end
      default: alu_ok = 1'b0;
    endcase
  end

  // highest pressed key wins
  always_comb begin
    top_key = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (keys_q[k]) top_key = 4'(k);
    end
  end
  assign any_key = |keys_q;

  // decimal digits of Vx; tens by reciprocal multiply, exact below 100
  always_comb begin
    if (vx_q >= 8'd200) begin
      bcd_h = 2'd2;
      bcd_r = 7'(vx_q - 8'd200);
    end else if (vx_q >= 8'd100) begin
      bcd_h = 2'd1;
      bcd_r = 7'(vx_q - 8'd100);
    end else begin
      bcd_h = 2'd0;
      bcd_r = vx_q[6:0];
    end
  end
  assign tens_prod = {8'd0, bcd_r} * 15'd205;
  assign bcd_t     = tens_prod[14:11];
  assign bcd_o     = {1'b0, bcd_r} - ({4'd0, bcd_t} * 8'd10);

  assign pc_fin  = (adv_q && !wait_q) ? pc_q + 12'd2 : pc_q;
  assign snd_fin = (snd_q != 8'd0) ? snd_q - 8'd1 : snd_q;

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    emit_d     = emit_q;
    pc_d       = pc_q;
    idx_d      = idx_q;
    sp_d       = sp_q;
    dly_d      = dly_q;
    snd_d      = snd_q;
    wait_d     = wait_q;
    held_d     = held_q;
    done_d     = 1'b0;
    keys_d     = keys_q;
    rnd_d      = rnd_q;
    hi_d       = hi_q;
    word_d     = word_q;
    vx_d       = vx_q;
    vy_d       = vy_q;
    adv_d      = adv_q;
    unk_d      = unk_q;
    chg_d      = chg_q;
    flag_d     = flag_q;
    cnt_d      = cnt_q;
    sprite_d   = sprite_q;
    bcd_d      = bcd_q;
    res_pc_d   = res_pc_q;
    res_word_d = res_word_q;
    res_halt_d = res_halt_q;
    res_chg_d  = res_chg_q;
    res_snd_d  = res_snd_q;
    res_unk_d  = res_unk_q;
    res_row_d  = res_row_q;

    m_we    = 1'b0;
    m_waddr = idx_off;
    m_wdata = v_rdata;
    m_raddr = pc_q;
    v_we    = 1'b0;
    v_waddr = ins_x;
    v_wdata = alu_res;
    v_raddr = ins_x;
    s_we    = 1'b0;
    s_waddr = sp_q + 4'd1;
    s_wdata = pc_q;
    f_we    = 1'b0;
    f_waddr = draw_row;
    f_wdata = f_rdata ^ draw_mask;
    f_raddr = row_index_i;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (opcode_i)
            OP_RESTART: begin
              idx_d   = 16'd0;
              pc_d    = PROGRAM_START;
              sp_d    = 4'd0;
              dly_d   = 8'd0;
              snd_d   = 8'd0;
              wait_d  = 1'b0;
              held_d  = NO_KEY;
              clr_d   = 12'd0;
              emit_d  = 1'b1;
              state_d = S_CLR;
            end
            OP_LOAD: begin
              m_we       = 1'b1;
              m_waddr    = address_i;
              m_wdata    = data_byte_i;
              done_d     = 1'b1;
              res_pc_d   = pc_q;
              res_word_d = 16'd0;
              res_halt_d = wait_q;
              res_chg_d  = 1'b0;
              res_snd_d  = snd_q != 8'd0;
              res_unk_d  = 1'b0;
              res_row_d  = 64'd0;
            end
            OP_STEP: begin
              keys_d  = keys_i;
              rnd_d   = random_byte_i;
              state_d = S_F0;
            end
            OP_READ: state_d = S_ROW;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLR: begin
        m_we    = 1'b1;
        m_waddr = clr_q;
        m_wdata = (clr_q < 12'(FontBytes)) ? HEX_FONT[clr_q[6:0]] : 8'd0;
        v_we    = 1'b1;
        v_waddr = clr_q[3:0];
        v_wdata = 8'd0;
        s_we    = 1'b1;
        s_waddr = clr_q[3:0];
        s_wdata = 12'd0;
        f_we    = 1'b1;
        f_waddr = clr_q[4:0];
        f_wdata = 64'd0;
        clr_d   = clr_q + 12'd1;
        if (clr_q == 12'(MemBytes - 1)) begin
          state_d = S_IDLE;
          emit_d  = 1'b0;
          if (emit_q) begin
            done_d     = 1'b1;
            res_pc_d   = pc_q;
            res_word_d = 16'd0;
            res_halt_d = 1'b0;
            res_chg_d  = 1'b0;
            res_snd_d  = 1'b0;
            res_unk_d  = 1'b0;
            res_row_d  = 64'd0;
          end
        end
      end
      S_ROW: begin
        done_d     = 1'b1;
        res_pc_d   = pc_q;
        res_word_d = 16'd0;
        res_halt_d = wait_q;
        res_chg_d  = 1'b0;
        res_snd_d  = snd_q != 8'd0;
        res_unk_d  = 1'b0;
        res_row_d  = f_rdata;
        state_d    = S_IDLE;
      end
      S_F0: begin
        m_raddr = pc_q;
        state_d = S_F1;
      end
      S_F1: begin
        hi_d    = m_rdata;
        m_raddr = pc_q + 12'd1;
        state_d = S_F2;
      end
      S_F2: begin
        word_d  = {hi_q, m_rdata};
        state_d = S_RX;
      end
      S_RX: begin
        v_raddr = ins_x;
        state_d = S_RY;
      end
      S_RY: begin
        vx_d    = v_rdata;
        // JP V0 needs V0 in place of Vy
        v_raddr = (word_q[15:12] == 4'hb) ? 4'd0 : ins_y;
        state_d = S_EX;
      end
      S_EX: begin
        vy_d    = v_rdata;
        adv_d   = 1'b1;
        unk_d   = 1'b0;
        chg_d   = 1'b0;
        cnt_d   = 6'd0;
        state_d = S_FIN;
        // any other instruction ends a key wait
        if (wait_q && !is_key_wait) begin
          wait_d = 1'b0;
          held_d = NO_KEY;
        end
        case (word_q[15:12])
          4'h0: begin
            if (word_q == 16'h00e0) begin
              state_d = S_CLS;
            end else if (word_q == 16'h00ee) begin
              state_d = S_RET;
            end else begin
              pc_d  = ins_nnn;
              adv_d = 1'b0;
            end
          end
          4'h1: begin
            pc_d  = ins_nnn;
            adv_d = 1'b0;
          end
          4'h2: begin
            sp_d  = sp_q + 4'd1;
            s_we  = 1'b1;
            pc_d  = ins_nnn;
            adv_d = 1'b0;
          end
          4'h3: if (vx_q == ins_kk) pc_d = pc_q + 12'd2;
          4'h4: if (vx_q != ins_kk) pc_d = pc_q + 12'd2;
          4'h5: if (vx_q == v_rdata) pc_d = pc_q + 12'd2;
          4'h6: begin
            v_we    = 1'b1;
            v_wdata = ins_kk;
          end
          4'h7: begin
            v_we    = 1'b1;
            v_wdata = vx_q + ins_kk;
          end
          4'h8: begin
            if (alu_ok) begin
              v_we    = 1'b1;
              v_wdata = alu_res;
              if (ins_n != 4'h0 && ins_n != 4'h1 && ins_n != 4'h2 && ins_n != 4'h3) begin
                flag_d  = alu_flag;
                state_d = S_FLG;
              end
            end else begin
              unk_d = 1'b1;
            end
          end
          4'h9: if (vx_q != v_rdata) pc_d = pc_q + 12'd2;
          4'ha: idx_d = {4'd0, ins_nnn};
          4'hb: begin
            pc_d  = ins_nnn + {4'd0, v_rdata};
            adv_d = 1'b0;
          end
          4'hc: begin
            v_we    = 1'b1;
            v_wdata = rnd_q & ins_kk;
          end
          4'hd: begin
            v_we    = 1'b1;
            v_waddr = FLAG_REG;
            v_wdata = 8'd0;
            if (ins_n != 4'd0) state_d = S_DR0;
          end
          4'he: begin
            if (ins_kk == 8'h9e) begin
              if (keys_q[vx_q[3:0]]) pc_d = pc_q + 12'd2;
            end else if (ins_kk == 8'ha1) begin
              if (!keys_q[vx_q[3:0]]) pc_d = pc_q + 12'd2;
            end else begin
              unk_d = 1'b1;
            end
          end
          default: begin
            case (ins_kk)
              8'h07: begin
                v_we    = 1'b1;
                v_wdata = dly_q;
              end
              8'h0a: begin
                if (wait_q && !held_q[4] && !keys_q[held_q[3:0]]) begin
                  wait_d = 1'b0;
                  held_d = NO_KEY;
                end else begin
                  wait_d = 1'b1;
                  if (any_key) begin
                    v_we    = 1'b1;
                    v_wdata = {4'd0, top_key};
                    held_d  = {1'b0, top_key};
                  end
                end
              end
              8'h15: dly_d = vx_q;
              8'h18: snd_d = vx_q;
              8'h1e: idx_d = idx_q + {8'd0, vx_q};
              8'h29: idx_d = {6'd0, vx_q, 2'd0} + {8'd0, vx_q};
              8'h33: begin
                bcd_d   = {2'd0, bcd_h, bcd_t, bcd_o[3:0]};
                state_d = S_BCD;
              end
              8'h55: state_d = S_ST0;
              8'h65: state_d = S_LD0;
              default: unk_d = 1'b1;
            endcase
          end
        endcase
      end
      S_RET: begin
        pc_d    = s_rdata;
        sp_d    = sp_q - 4'd1;
        state_d = S_FIN;
      end
      S_FLG: begin
        v_we    = 1'b1;
        v_waddr = FLAG_REG;
        v_wdata = {7'd0, flag_q};
        state_d = S_FIN;
      end
      S_CLS: begin
        // read and zero row cnt; check the row read last cycle
        f_raddr = cnt_q[4:0];
        f_waddr = cnt_q[4:0];
        f_wdata = 64'd0;
        f_we    = !cnt_q[5];
        if (cnt_q != 6'd0 && f_rdata != 64'd0) chg_d = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q[5]) state_d = S_FIN;
      end
      S_DR0: begin
        m_raddr = idx_off;
        state_d = S_DR1;
      end
      S_DR1: begin
        sprite_d = m_rdata;
        f_raddr  = draw_row;
        state_d  = S_DR2;
      end
      S_DR2: begin
        f_we    = 1'b1;
        f_waddr = draw_row;
        f_wdata = f_rdata ^ draw_mask;
        if ((f_rdata & draw_mask) != 64'd0) begin
          v_we    = 1'b1;
          v_waddr = FLAG_REG;
          v_wdata = 8'd1;
        end
        if (sprite_q != 8'd0) chg_d = 1'b1;
        cnt_d   = cnt_q + 6'd1;
        state_d = (cnt_q[3:0] == ins_n - 4'd1) ? S_FIN : S_DR0;
      end
      S_BCD: begin
        m_we    = 1'b1;
        m_waddr = idx_off;
        case (cnt_q[1:0])
          2'd0:    m_wdata = {4'd0, bcd_q[11:8]};
          2'd1:    m_wdata = {4'd0, bcd_q[7:4]};
          default: m_wdata = {4'd0, bcd_q[3:0]};
        endcase
        cnt_d   = cnt_q + 6'd1;
        if (cnt_q[1:0] == 2'd2) state_d = S_FIN;
      end
      S_ST0: begin
        v_raddr = cnt_q[3:0];
        state_d = S_ST1;
      end
      S_ST1: begin
        m_we    = 1'b1;
        m_waddr = idx_off;
        m_wdata = v_rdata;
        cnt_d   = cnt_q + 6'd1;
        state_d = (cnt_q[3:0] == ins_x) ? S_FIN : S_ST0;
      end
      S_LD0: begin
        m_raddr = idx_off;
        state_d = S_LD1;
      end
      S_LD1: begin
        v_we    = 1'b1;
        v_waddr = cnt_q[3:0];
        v_wdata = m_rdata;
        cnt_d   = cnt_q + 6'd1;
        state_d = (cnt_q[3:0] == ins_x) ? S_FIN : S_LD0;
      end
      S_FIN: begin
        pc_d       = pc_fin;
        dly_d      = (dly_q != 8'd0) ? dly_q - 8'd1 : dly_q;
        snd_d      = snd_fin;
        done_d     = 1'b1;
        res_pc_d   = pc_fin;
        res_word_d = word_q;
        res_halt_d = wait_q;
        res_chg_d  = chg_q;
        res_snd_d  = snd_fin != 8'd0;
        res_unk_d  = unk_q;
        res_row_d  = 64'd0;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q   <= 12'd0;
      emit_q  <= 1'b0;
      pc_q    <= PROGRAM_START;
      idx_q   <= 16'd0;
      sp_q    <= 4'd0;
      dly_q   <= 8'd0;
      snd_q   <= 8'd0;
      wait_q  <= 1'b0;
      held_q  <= NO_KEY;
      done_q  <= 1'b0;
      cnt_q   <= 6'd0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      emit_q  <= emit_d;
      pc_q    <= pc_d;
      idx_q   <= idx_d;
      sp_q    <= sp_d;
      dly_q   <= dly_d;
      snd_q   <= snd_d;
      wait_q  <= wait_d;
      held_q  <= held_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    keys_q     <= keys_d;
    rnd_q      <= rnd_d;
    hi_q       <= hi_d;
    word_q     <= word_d;
    vx_q       <= vx_d;
    vy_q       <= vy_d;
    adv_q      <= adv_d;
    unk_q      <= unk_d;
    chg_q      <= chg_d;
    flag_q     <= flag_d;
    sprite_q   <= sprite_d;
    bcd_q      <= bcd_d;
    res_pc_q   <= res_pc_d;
    res_word_q <= res_word_d;
    res_halt_q <= res_halt_d;
    res_chg_q  <= res_chg_d;
    res_snd_q  <= res_snd_d;
    res_unk_q  <= res_unk_d;
    res_row_q  <= res_row_d;
  end

  assign busy                  = state_q != S_IDLE;
  assign done_o                = done_q;
  assign program_counter_o     = res_pc_q;
  assign fetched_word_o        = res_word_q;
  assign halted_o              = res_halt_q;
  assign display_changed_o     = res_chg_q;
  assign sound_on_o            = res_snd_q;
  assign unknown_instruction_o = res_unk_q;
  assign row_pixels_o          = res_row_q;

`ifndef SYNTHESIS
  // a held key only exists during a key wait
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != NO_KEY) |-> wait_q)
    else $error("held key without key wait");

  // results are only shown once the sequencer is back in idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == S_IDLE))
    else $error("result shown while busy");

  // restart always enters the clearing sweep
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && opcode_i == OP_RESTART) |=> (state_q == S_CLR && clr_q == 12'd0))
    else $error("restart did not start the sweep");
`endif

endmodule
`default_nettype wire

[rtl/c8cpu_ram.sv]
// Generic simple dual-port RAM with registered read (old data on collision).
`timescale 1ns / 1ps
`default_nettype none
module c8cpu_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire
